[design/esp_pkg.sv]
// Shared types, codes and reset values for the encoder serial programmer.
package esp_pkg;

  localparam int DEF_WORD_COUNT = 12;
  localparam int DEF_WORD_BITS  = 16;

  localparam int OP_W         = 2;
  localparam int WORD_INDEX_W = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int TICK_W       = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_VERIFY = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_START_LONG   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_GAP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_SETTLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_LOW      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_HOLD    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_VERIFY_SETUP = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DELAY = 3'd7;

  localparam logic [TICK_W-1:0] START_LONG_RST   = 16'd4000;
  localparam logic [TICK_W-1:0] START_GAP_RST    = 16'd50;
  localparam logic [TICK_W-1:0] START_SETTLE_RST = 16'd3500;
  localparam logic [TICK_W-1:0] BIT_HIGH_RST     = 16'd26;
  localparam logic [TICK_W-1:0] BIT_LOW_RST      = 16'd30;
  localparam logic [TICK_W-1:0] WORD_HOLD_RST    = 16'd35000;
  localparam logic [TICK_W-1:0] VERIFY_SETUP_RST = 16'd20;
  localparam logic [TICK_W-1:0] SAMPLE_DELAY_RST = 16'd5;

  typedef struct packed {
    logic [TICK_W-1:0] start_long;
    logic [TICK_W-1:0] start_gap;
    logic [TICK_W-1:0] start_settle;
    logic [TICK_W-1:0] bit_high;
    logic [TICK_W-1:0] bit_low;
    logic [TICK_W-1:0] word_hold;
    logic [TICK_W-1:0] verify_setup;
    logic [TICK_W-1:0] sample_delay;
  } cfg_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic data_drive;
    logic busy;
    logic verify_done;
    logic verify_ok;
  } status_t;

endpackage

[design/encoder_serial_programmer.sv]
// Top level of the encoder serial programmer: channel registers and submodules.
//
// Usage:
//   in_* is the transaction channel: op selects write word, start load,
//   start verify or a one-microsecond tick; word_index/word_value serve a
//   word write and data_in carries the sampled data line during ticks.
//   out_* returns one transaction per input transaction with the line
//   levels, busy flag and verify status as they stand after that item.
//   cfg_we/cfg_index/cfg_wdata write the eight timing registers; write them
//   only while no sequence runs and no transaction is in flight.
// Path: from input acceptance to out_valid through the input register, then
//   the sequencer and status registers.
// Throughput: one transaction per cycle while out_stall is low, set by the
//   sequencer update between the input register and the status registers.
// Reset: sequencer idle, lines low and released, verify_ok set, verify_done
//   clear, timing registers at their defaults; the word buffer holds no
//   defined value until written.
// Stall: while out_stall holds a result, sequencer state holds and the input
//   register fills once; in_stall then rises until the result is taken.
module encoder_serial_programmer #(
  parameter int WORD_COUNT = esp_pkg::DEF_WORD_COUNT,
  parameter int WORD_BITS  = esp_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [esp_pkg::OP_W-1:0]          in_op,
  input  logic [esp_pkg::WORD_INDEX_W-1:0]  in_word_index,
  input  logic [WORD_BITS-1:0]              in_word_value,
  input  logic                              in_data_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_clock_level,
  output logic                              out_data_level,
  output logic                              out_data_drive,
  output logic                              out_busy_res,
  output logic                              out_verify_done,
  output logic                              out_verify_ok,
  input  logic                              cfg_we,
  input  logic [esp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                              s1_valid_r;
  logic [esp_pkg::OP_W-1:0]          s1_op_r;
  logic [esp_pkg::WORD_INDEX_W-1:0]  s1_index_r;
  logic [WORD_BITS-1:0]              s1_value_r;
  logic                              s1_din_r;
  logic                              out_valid_r;
  logic                              go;
  esp_pkg::cfg_t                     cfg;
  esp_pkg::status_t                  stat;

  assign go       = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r    <= in_op;
      s1_index_r <= in_word_index;
      s1_value_r <= in_word_value;
      s1_din_r   <= in_data_in;
    end
  end

  esp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esp_seq #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (s1_valid_r && go),
    .op         (s1_op_r),
    .word_index (s1_index_r),
    .word_value (s1_value_r),
    .data_in    (s1_din_r),
    .cfg        (cfg),
    .stat       (stat)
  );

  assign out_valid       = out_valid_r;
  assign out_clock_level = stat.clock_level;
  assign out_data_level  = stat.data_level;
  assign out_data_drive  = stat.data_drive;
  assign out_busy_res    = stat.busy;
  assign out_verify_done = stat.verify_done;
  assign out_verify_ok   = stat.verify_ok;

endmodule

[design/esp_cfg_regs.sv]
// Timing register file written through the configuration port.
module esp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [esp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output esp_pkg::cfg_t                    cfg
);

  esp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_long   <= esp_pkg::START_LONG_RST;
      cfg_r.start_gap    <= esp_pkg::START_GAP_RST;
      cfg_r.start_settle <= esp_pkg::START_SETTLE_RST;
      cfg_r.bit_high     <= esp_pkg::BIT_HIGH_RST;
      cfg_r.bit_low      <= esp_pkg::BIT_LOW_RST;
      cfg_r.word_hold    <= esp_pkg::WORD_HOLD_RST;
      cfg_r.verify_setup <= esp_pkg::VERIFY_SETUP_RST;
      cfg_r.sample_delay <= esp_pkg::SAMPLE_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        esp_pkg::REG_START_LONG:   cfg_r.start_long   <= cfg_wdata;
        esp_pkg::REG_START_GAP:    cfg_r.start_gap    <= cfg_wdata;
        esp_pkg::REG_START_SETTLE: cfg_r.start_settle <= cfg_wdata;
        esp_pkg::REG_BIT_HIGH:     cfg_r.bit_high     <= cfg_wdata;
        esp_pkg::REG_BIT_LOW:      cfg_r.bit_low      <= cfg_wdata;
        esp_pkg::REG_WORD_HOLD:    cfg_r.word_hold    <= cfg_wdata;
        esp_pkg::REG_VERIFY_SETUP: cfg_r.verify_setup <= cfg_wdata;
        esp_pkg::REG_SAMPLE_DELAY: cfg_r.sample_delay <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/esp_seq.sv]
// Word buffer and load/verify line sequencer, one transaction per cycle in which item_go is high.
module esp_seq #(
  parameter int WORD_COUNT = esp_pkg::DEF_WORD_COUNT,
  parameter int WORD_BITS  = esp_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_go,
  input  logic [esp_pkg::OP_W-1:0]          op,
  input  logic [esp_pkg::WORD_INDEX_W-1:0]  word_index,
  input  logic [WORD_BITS-1:0]              word_value,
  input  logic                              data_in,
  input  esp_pkg::cfg_t                     cfg,
  output esp_pkg::status_t                  stat
);

  localparam int CW = $clog2(WORD_COUNT + 1);
  localparam int BW = $clog2(WORD_BITS + 1);
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int TW = esp_pkg::TICK_W;

  typedef enum logic [3:0] {
    PH_IDLE, PH_L_CLK, PH_L_DATA, PH_L_GAP, PH_L_SETTLE, PH_L_BITHI,
    PH_L_BITLO, PH_L_HOLD, PH_V_SETUP, PH_V_CLKHI, PH_V_SAMPLE, PH_V_REST
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   wc_r, wc_nxt;
  logic [BW-1:0]   bc_r, bc_nxt;
  logic [TW-1:0]   timer_r, timer_nxt;
  logic            match_r, match_nxt;
  logic            done_r, done_nxt;
  logic            clk_r, clk_nxt;
  logic            dat_r, dat_nxt;
  logic            drv_r, drv_nxt;

  logic [WORD_BITS-1:0] wbuf_r [WORD_COUNT];

  esp_pkg::op_t         op_c;
  logic                 idle;
  logic [AW+3:0]        wr_ext;
  logic                 wr_en;
  logic [CW-1:0]        rd_wc;
  logic [BW-1:0]        rd_bc;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] rd_shift;
  logic                 rd_bit;
  logic [TW-1:0]        rest_ticks;

  assign op_c   = esp_pkg::op_t'(op);
  assign idle   = (phase_r == PH_IDLE);
  assign wr_ext = (AW + 4)'(word_index);
  assign wr_en  = item_go && (op_c == esp_pkg::OP_WRITE) && idle &&
                  (32'(word_index) < WORD_COUNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wbuf_r[wr_ext[AW-1:0]] <= word_value;
    end
  end

  always_comb begin
    rd_wc = wc_r;
    rd_bc = bc_r;
    case (phase_r)
      PH_L_SETTLE: begin
        rd_wc = '0;
        rd_bc = '0;
      end
      PH_L_BITLO: rd_bc = bc_r + BW'(1);
      PH_L_HOLD: begin
        rd_wc = wc_r + CW'(1);
        rd_bc = '0;
      end
      default: ;
    endcase
  end

  assign rd_word  = wbuf_r[rd_wc[AW-1:0]];
  assign rd_shift = rd_word >> rd_bc;
  assign rd_bit   = (rd_wc < CW'(WORD_COUNT)) ? rd_shift[0] : 1'b0;

  assign rest_ticks = (cfg.bit_high > cfg.sample_delay) ?
                      (cfg.bit_high - cfg.sample_delay) : '0;

  always_comb begin
    phase_nxt = phase_r;
    wc_nxt    = wc_r;
    bc_nxt    = bc_r;
    timer_nxt = timer_r;
    match_nxt = match_r;
    done_nxt  = done_r;
    clk_nxt   = clk_r;
    dat_nxt   = dat_r;
    drv_nxt   = drv_r;
    if (item_go) begin
      case (op_c)
        esp_pkg::OP_LOAD: begin
          if (idle) begin
            drv_nxt   = 1'b1;
            clk_nxt   = 1'b1;
            dat_nxt   = 1'b0;
            wc_nxt    = '0;
            bc_nxt    = '0;
            phase_nxt = PH_L_CLK;
            timer_nxt = cfg.start_long;
          end
        end
        esp_pkg::OP_VERIFY: begin
          if (idle) begin
            drv_nxt   = 1'b0;
            dat_nxt   = 1'b0;
            match_nxt = 1'b1;
            done_nxt  = 1'b0;
            wc_nxt    = '0;
            bc_nxt    = '0;
            phase_nxt = PH_V_SETUP;
            timer_nxt = cfg.verify_setup;
          end
        end
        esp_pkg::OP_TICK: begin
          if (!idle) begin
            if (timer_r > TW'(1)) begin
              timer_nxt = timer_r - TW'(1);
            end else begin
              case (phase_r)
                PH_L_CLK: begin
                  dat_nxt   = 1'b1;
                  phase_nxt = PH_L_DATA;
                  timer_nxt = cfg.start_long;
                end
                PH_L_DATA: begin
                  dat_nxt   = 1'b0;
                  phase_nxt = PH_L_GAP;
                  timer_nxt = cfg.start_gap;
                end
                PH_L_GAP: begin
                  clk_nxt   = 1'b0;
                  phase_nxt = PH_L_SETTLE;
                  timer_nxt = cfg.start_settle;
                end
                PH_L_SETTLE: begin
                  wc_nxt    = '0;
                  bc_nxt    = '0;
                  clk_nxt   = 1'b1;
                  dat_nxt   = rd_bit;
                  phase_nxt = PH_L_BITHI;
                  timer_nxt = cfg.bit_high;
                end
                PH_L_BITHI: begin
                  clk_nxt   = 1'b0;
                  phase_nxt = PH_L_BITLO;
                  timer_nxt = cfg.bit_low;
                end
                PH_L_BITLO: begin
                  bc_nxt = bc_r + BW'(1);
                  if (bc_nxt < BW'(WORD_BITS)) begin
                    clk_nxt   = 1'b1;
                    dat_nxt   = rd_bit;
                    phase_nxt = PH_L_BITHI;
                    timer_nxt = cfg.bit_high;
                  end else begin
                    clk_nxt   = 1'b0;
                    dat_nxt   = 1'b0;
                    phase_nxt = PH_L_HOLD;
                    timer_nxt = cfg.word_hold;
                  end
                end
                PH_L_HOLD: begin
                  wc_nxt = wc_r + CW'(1);
                  bc_nxt = '0;
                  if (wc_nxt < CW'(WORD_COUNT)) begin
                    clk_nxt   = 1'b1;
                    dat_nxt   = rd_bit;
                    phase_nxt = PH_L_BITHI;
                    timer_nxt = cfg.bit_high;
                  end else begin
                    phase_nxt = PH_IDLE;
                    timer_nxt = '0;
                  end
                end
                PH_V_SETUP: begin
                  wc_nxt    = '0;
                  bc_nxt    = '0;
                  clk_nxt   = 1'b1;
                  phase_nxt = PH_V_CLKHI;
                  timer_nxt = cfg.bit_low;
                end
                PH_V_CLKHI: begin
                  clk_nxt   = 1'b0;
                  phase_nxt = PH_V_SAMPLE;
                  timer_nxt = cfg.sample_delay;
                end
                PH_V_SAMPLE: begin
                  if (data_in != rd_bit) begin
                    match_nxt = 1'b0;
                  end
                  phase_nxt = PH_V_REST;
                  timer_nxt = rest_ticks;
                end
                PH_V_REST: begin
                  bc_nxt = bc_r + BW'(1);
                  if (bc_nxt >= BW'(WORD_BITS)) begin
                    bc_nxt = '0;
                    wc_nxt = wc_r + CW'(1);
                  end
                  if (wc_nxt < CW'(WORD_COUNT)) begin
                    clk_nxt   = 1'b1;
                    phase_nxt = PH_V_CLKHI;
                    timer_nxt = cfg.bit_low;
                  end else begin
                    done_nxt  = 1'b1;
                    phase_nxt = PH_IDLE;
                    timer_nxt = '0;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  timer_nxt = '0;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wc_r    <= '0;
      bc_r    <= '0;
      timer_r <= '0;
      match_r <= 1'b1;
      done_r  <= 1'b0;
      clk_r   <= 1'b0;
      dat_r   <= 1'b0;
      drv_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wc_r    <= wc_nxt;
      bc_r    <= bc_nxt;
      timer_r <= timer_nxt;
      match_r <= match_nxt;
      done_r  <= done_nxt;
      clk_r   <= clk_nxt;
      dat_r   <= dat_nxt;
      drv_r   <= drv_nxt;
    end
  end

  assign stat.clock_level = clk_r;
  assign stat.data_level  = drv_r & dat_r;
  assign stat.data_drive  = drv_r;
  assign stat.busy        = !idle;
  assign stat.verify_done = done_r;
  assign stat.verify_ok   = match_r;

  a_dat_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    dat_r |-> drv_r)
    else $error("data high while line released");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (bc_r <= BW'(WORD_BITS)) && (wc_r <= CW'(WORD_COUNT)))
    else $error("word or bit count out of range");

  a_verify_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(!idle) && !drv_r |-> done_r)
    else $error("verify finished without done flag");

  a_match_falls_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(match_r) |-> $past(phase_r == PH_V_SAMPLE))
    else $error("ok flag cleared outside sample phase");

endmodule

[verif/tb_encoder_serial_programmer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the encoder serial programmer: line-level prediction per transaction.
module tb_encoder_serial_programmer;
  import esp_pkg::*;

  localparam int WORD_COUNT  = DEF_WORD_COUNT;
  localparam int WORD_BITS   = DEF_WORD_BITS;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 900;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_LD_CLK, SQ_LD_DATA, SQ_LD_GAP, SQ_LD_SETTLE, SQ_LD_BIT_HI,
    SQ_LD_BIT_LO, SQ_LD_HOLD, SQ_VF_SETUP, SQ_VF_CLK_HI, SQ_VF_SAMPLE, SQ_VF_REST
  } seq_phase_e;

  typedef enum int {ST_NONE, ST_LIGHT, ST_HEAVY, ST_TOGGLE} stall_style_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_op;
  logic [WORD_INDEX_W-1:0] in_word_index;
  logic [WORD_BITS-1:0] in_word_value;
  logic in_data_in;
  logic out_valid;
  logic out_stall;
  logic out_clock_level;
  logic out_data_level;
  logic out_data_drive;
  logic out_busy_res;
  logic out_verify_done;
  logic out_verify_ok;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [WORD_BITS-1:0] word_mem [WORD_COUNT];
  seq_phase_e seq_phase;
  int unsigned word_ptr;
  int unsigned bit_ptr;
  logic [TICK_W-1:0] tick_left;
  logic match_flag;
  logic done_flag;
  logic clk_line;
  logic dat_line;
  logic drv_line;
  cfg_t timing;

  status_t pending_status [$];
  int unsigned items_sent;
  int errors;
  int burst_left;

  encoder_serial_programmer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_word_index   (in_word_index),
    .in_word_value   (in_word_value),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clock_level (out_clock_level),
    .out_data_level  (out_data_level),
    .out_data_drive  (out_data_drive),
    .out_busy_res    (out_busy_res),
    .out_verify_done (out_verify_done),
    .out_verify_ok   (out_verify_ok),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #32_000_000;
    $display("FAIL encoder_serial_programmer");
    $finish;
  end

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      report_error($sformatf("%s: expected %0b, actual %0b", name, want, got));
    end
  endtask

  function automatic logic stored_bit();
    if (word_ptr >= WORD_COUNT || bit_ptr >= WORD_BITS) return 1'b0;
    return word_mem[word_ptr][bit_ptr];
  endfunction

  task automatic set_phase(seq_phase_e p, logic [TICK_W-1:0] d);
    seq_phase = p;
    tick_left = d;
  endtask

  task automatic begin_write_bit();
    clk_line = 1'b1;
    dat_line = stored_bit();
    set_phase(SQ_LD_BIT_HI, timing.bit_high);
  endtask

  task automatic begin_read_bit();
    clk_line = 1'b1;
    set_phase(SQ_VF_CLK_HI, timing.bit_low);
  endtask

  task automatic advance_sequence(logic din);
    case (seq_phase)
      SQ_LD_CLK: begin
        dat_line = 1'b1;
        set_phase(SQ_LD_DATA, timing.start_long);
      end
      SQ_LD_DATA: begin
        dat_line = 1'b0;
        set_phase(SQ_LD_GAP, timing.start_gap);
      end
      SQ_LD_GAP: begin
        clk_line = 1'b0;
        set_phase(SQ_LD_SETTLE, timing.start_settle);
      end
      SQ_LD_SETTLE: begin
        word_ptr = 0;
        bit_ptr = 0;
        begin_write_bit();
      end
      SQ_LD_BIT_HI: begin
        clk_line = 1'b0;
        set_phase(SQ_LD_BIT_LO, timing.bit_low);
      end
      SQ_LD_BIT_LO: begin
        bit_ptr++;
        if (bit_ptr < WORD_BITS) begin
          begin_write_bit();
        end else begin
          clk_line = 1'b0;
          dat_line = 1'b0;
          set_phase(SQ_LD_HOLD, timing.word_hold);
        end
      end
      SQ_LD_HOLD: begin
        word_ptr++;
        bit_ptr = 0;
        if (word_ptr < WORD_COUNT) begin_write_bit();
        else set_phase(SQ_IDLE, '0);
      end
      SQ_VF_SETUP: begin
        word_ptr = 0;
        bit_ptr = 0;
        begin_read_bit();
      end
      SQ_VF_CLK_HI: begin
        clk_line = 1'b0;
        set_phase(SQ_VF_SAMPLE, timing.sample_delay);
      end
      SQ_VF_SAMPLE: begin
        if (din != stored_bit()) match_flag = 1'b0;
        set_phase(SQ_VF_REST, (timing.bit_high > timing.sample_delay) ?
                  timing.bit_high - timing.sample_delay : '0);
      end
      SQ_VF_REST: begin
        bit_ptr++;
        if (bit_ptr >= WORD_BITS) begin
          bit_ptr = 0;
          word_ptr++;
        end
        if (word_ptr < WORD_COUNT) begin
          begin_read_bit();
        end else begin
          done_flag = 1'b1;
          set_phase(SQ_IDLE, '0);
        end
      end
      default: set_phase(SQ_IDLE, '0);
    endcase
  endtask

  task automatic predict_line_status(op_t op, logic [WORD_INDEX_W-1:0] idx,
                                     logic [WORD_BITS-1:0] val, logic din);
    status_t s;
    logic idle;
    idle = (seq_phase == SQ_IDLE);
    case (op)
      OP_WRITE: begin
        if (idle && idx < WORD_COUNT) word_mem[idx] = val;
      end
      OP_LOAD: begin
        if (idle) begin
          drv_line = 1'b1;
          clk_line = 1'b1;
          dat_line = 1'b0;
          word_ptr = 0;
          bit_ptr = 0;
          set_phase(SQ_LD_CLK, timing.start_long);
        end
      end
      OP_VERIFY: begin
        if (idle) begin
          drv_line = 1'b0;
          dat_line = 1'b0;
          match_flag = 1'b1;
          done_flag = 1'b0;
          word_ptr = 0;
          bit_ptr = 0;
          set_phase(SQ_VF_SETUP, timing.verify_setup);
        end
      end
      default: begin
        if (!idle) begin
          if (tick_left > 1) tick_left--;
          else advance_sequence(din);
        end
      end
    endcase
    s.clock_level = clk_line;
    s.data_level  = drv_line & dat_line;
    s.data_drive  = drv_line;
    s.busy        = (seq_phase != SQ_IDLE);
    s.verify_done = done_flag;
    s.verify_ok   = match_flag;
    pending_status.push_back(s);
  endtask

  task automatic send_item(op_t op, logic [WORD_INDEX_W-1:0] idx,
                           logic [WORD_BITS-1:0] val, logic din);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_word_index = idx;
    in_word_value = val;
    in_data_in = din;
    do @(posedge clk); while (in_stall);
    predict_line_status(op, idx, val, din);
    items_sent++;
  endtask

  task automatic send_tick(int flip_per_mille);
    logic din;
    din = 1'($urandom_range(0, 1));
    if (seq_phase == SQ_VF_SAMPLE && tick_left <= 1) begin
      din = stored_bit() ^ ($urandom_range(0, 999) < flip_per_mille);
    end
    send_item(OP_TICK, 4'($urandom_range(0, 15)), 16'($urandom), din);
  endtask

  task automatic run_to_idle(int flip_per_mille, int noise_pct);
    while (seq_phase != SQ_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(op_t'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                  16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        send_tick(flip_per_mille);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      REG_START_LONG:   timing.start_long = value;
      REG_START_GAP:    timing.start_gap = value;
      REG_START_SETTLE: timing.start_settle = value;
      REG_BIT_HIGH:     timing.bit_high = value;
      REG_BIT_LOW:      timing.bit_low = value;
      REG_WORD_HOLD:    timing.word_hold = value;
      REG_VERIFY_SETUP: timing.verify_setup = value;
      default:          timing.sample_delay = value;
    endcase
  endtask

  task automatic apply_timing(cfg_t t);
    run_to_idle(0, 0);
    drain_results();
    write_reg(REG_START_LONG, t.start_long);
    write_reg(REG_START_GAP, t.start_gap);
    write_reg(REG_START_SETTLE, t.start_settle);
    write_reg(REG_BIT_HIGH, t.bit_high);
    write_reg(REG_BIT_LOW, t.bit_low);
    write_reg(REG_WORD_HOLD, t.word_hold);
    write_reg(REG_VERIFY_SETUP, t.verify_setup);
    write_reg(REG_SAMPLE_DELAY, t.sample_delay);
  endtask

  task automatic test_reset_and_buffer();
    logic [WORD_BITS-1:0] value;
    send_item(OP_TICK, 4'hF, 16'hFFFF, 1'b1);
    send_item(OP_TICK, 4'h0, 16'h0000, 1'b0);
    for (int i = 0; i < WORD_COUNT; i++) begin
      case (i)
        0:       value = 16'h0000;
        1:       value = 16'hFFFF;
        2:       value = 16'hAAAA;
        3:       value = 16'h5555;
        default: value = 16'($urandom);
      endcase
      send_item(OP_WRITE, 4'(i), value, 1'b0);
    end
    send_item(OP_WRITE, 4'(WORD_COUNT), 16'hFFFF, 1'b1);
    send_item(OP_WRITE, 4'hF, 16'h1234, 1'b0);
  endtask

  task automatic test_zero_timing_load();
    apply_timing('0);
    send_item(OP_LOAD, 4'h0, 16'h0000, 1'b0);
    run_to_idle(0, 10);
    send_item(OP_TICK, 4'h3, 16'h0F0F, 1'b1);
  endtask

  task automatic test_verify_short_rest();
    cfg_t t;
    t = '0;
    t.bit_high = 16'd1;
    t.bit_low = 16'd2;
    t.sample_delay = 16'd3;
    t.verify_setup = 16'd4;
    apply_timing(t);
    send_item(OP_VERIFY, 4'h0, 16'h0000, 1'b0);
    run_to_idle(0, 5);
    send_item(OP_TICK, 4'h0, 16'h0000, 1'b0);
  endtask

  task automatic test_verify_mismatch();
    cfg_t t;
    t = '0;
    t.bit_high = 16'd3;
    t.bit_low = 16'd1;
    t.sample_delay = 16'd1;
    apply_timing(t);
    send_item(OP_VERIFY, 4'h0, 16'h0000, 1'b0);
    run_to_idle(1000, 5);
    send_item(OP_VERIFY, 4'h0, 16'h0000, 1'b0);
    run_to_idle(0, 0);
  endtask

  task automatic test_max_start_gap();
    cfg_t t;
    t = '0;
    t.start_gap = 16'hFFFF;
    apply_timing(t);
    send_item(OP_LOAD, 4'h0, 16'h0000, 1'b0);
    run_to_idle(0, 1);
  endtask

  task automatic test_random_rounds();
    cfg_t t;
    int unsigned first;
    int rounds;
    int flips;
    first = items_sent;
    rounds = 0;
    while (items_sent - first < RANDOM_ITEMS || rounds < 4) begin
      t.start_long = 16'($urandom_range(0, 3));
      t.start_gap = 16'($urandom_range(0, 3));
      t.start_settle = 16'($urandom_range(0, 3));
      t.bit_high = 16'($urandom_range(0, 3));
      t.bit_low = 16'($urandom_range(0, 3));
      t.word_hold = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 40))
                                                : 16'($urandom_range(0, 3));
      t.verify_setup = 16'($urandom_range(0, 3));
      t.sample_delay = 16'($urandom_range(0, 4));
      apply_timing(t);
      repeat ($urandom_range(0, 8)) begin
        send_item(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_TICK,
                  4'($urandom_range(0, 15)), 16'($urandom), 1'($urandom_range(0, 1)));
      end
      flips = 0;
      if ($urandom_range(0, 1) != 0) begin
        send_item(OP_LOAD, 4'($urandom_range(0, 15)), 16'($urandom), 1'b0);
      end else begin
        if ($urandom_range(0, 1) != 0) flips = $urandom_range(1, 8);
        send_item(OP_VERIFY, 4'($urandom_range(0, 15)), 16'($urandom), 1'b0);
      end
      run_to_idle(flips, 5);
      rounds++;
    end
  endtask

  initial begin
    stall_style_e style;
    int seg;
    out_stall = 1'b0;
    forever begin
      seg = $urandom_range(10, 150);
      style = stall_style_e'($urandom_range(0, 3));
      repeat (seg) begin
        @(negedge clk);
        case (style)
          ST_NONE:  out_stall = 1'b0;
          ST_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          ST_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:  out_stall = ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_error("result transaction with nothing expected");
      end else begin
        want = pending_status.pop_front();
        check_field("clock_level", want.clock_level, out_clock_level);
        check_field("data_level", want.data_level, out_data_level);
        check_field("data_drive", want.data_drive, out_data_drive);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("verify_done", want.verify_done, out_verify_done);
        check_field("verify_ok", want.verify_ok, out_verify_ok);
      end
    end
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_word_index = '0;
    in_word_value = '0;
    in_data_in = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_START_LONG;
    cfg_wdata = '0;
    items_sent = 0;
    errors = 0;
    burst_left = 0;
    foreach (word_mem[i]) word_mem[i] = '0;
    seq_phase = SQ_IDLE;
    word_ptr = 0;
    bit_ptr = 0;
    tick_left = '0;
    match_flag = 1'b1;
    done_flag = 1'b0;
    clk_line = 1'b0;
    dat_line = 1'b0;
    drv_line = 1'b0;
    timing.start_long = START_LONG_RST;
    timing.start_gap = START_GAP_RST;
    timing.start_settle = START_SETTLE_RST;
    timing.bit_high = BIT_HIGH_RST;
    timing.bit_low = BIT_LOW_RST;
    timing.word_hold = WORD_HOLD_RST;
    timing.verify_setup = VERIFY_SETUP_RST;
    timing.sample_delay = SAMPLE_DELAY_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_and_buffer();
    test_zero_timing_load();
    test_verify_short_rest();
    test_verify_mismatch();
    test_max_start_gap();
    test_random_rounds();

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_status.size() != 0) begin
      report_error($sformatf("%0d result transactions never arrived", pending_status.size()));
    end
    if (errors == 0) begin
      $display("PASS encoder_serial_programmer");
    end else begin
      $display("FAIL encoder_serial_programmer");
    end
    $finish;
  end

endmodule

[sim.f]
design/esp_pkg.sv
design/esp_cfg_regs.sv
design/esp_seq.sv
design/encoder_serial_programmer.sv
verif/tb_encoder_serial_programmer.sv
